>>> src/psim_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psim_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ADDR_BITS  = 32;
  localparam int unsigned DATA_BITS  = 32;

  localparam int unsigned CHAN_W  = 10;
  localparam int unsigned OUTC_W  = 13;
  localparam int unsigned PAD_W   = 10;
  localparam int unsigned DREG_W  = 13;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = (DATA_BITS > DREG_W) ? DATA_BITS : DREG_W;

  // effective dimension holds 1 .. 2^COORD_BITS
  localparam int unsigned DIM_W = COORD_BITS + 1;
  localparam int unsigned CMP_W = (DIM_W > DREG_W) ? DIM_W : DREG_W;
  // signed width for per-axis arithmetic, covers 2*(n-1) - d and -d
  localparam int unsigned AX_W  = (DIM_W + 3 > OUTC_W + 2) ? DIM_W + 3 : OUTC_W + 2;

  typedef enum logic [MODE_W-1:0] {
    PAD_CONST   = 2'd0,
    PAD_EDGE    = 2'd1,
    PAD_REFLECT = 2'd2
  } pad_mode_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PAD_MODE   = 3'd0,
    CFG_PAD_LEFT   = 3'd1,
    CFG_PAD_TOP    = 3'd2,
    CFG_PAD_FRONT  = 3'd3,
    CFG_IN_WIDTH   = 3'd4,
    CFG_IN_HEIGHT  = 3'd5,
    CFG_IN_DEPTH   = 3'd6,
    CFG_FILL_VALUE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                  fill;
    logic                  bad;
    logic [COORD_BITS-1:0] coord;
  } axis_res_t;

  typedef struct packed {
    logic                  fill;
    logic                  bad;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] sz;
  } side_t;

  // zero reads as one, anything above 2^COORD_BITS saturates
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DREG_W-1:0] r);
    logic [CMP_W-1:0] rx;
    logic [CMP_W-1:0] cap;
    rx  = CMP_W'(r);
    cap = CMP_W'(1) << COORD_BITS;
    if (rx == '0) begin
      return DIM_W'(1);
    end else if (rx > cap) begin
      return DIM_W'(cap);
    end
    return DIM_W'(rx);
  endfunction

endpackage

`default_nettype wire

>>> src/pad_source_index_map_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// request   start_i / busy_o           chan_i, out_z_i, out_y_i, out_x_i
// result    valid_o (one-cycle strobe) src_x_o, src_y_o, src_z_o, src_address_o,
//                                      use_fill_o, fill_out_o, out_of_range_o
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle; busy_o stays low. Each request flows through a pipeline:
// one stage maps the three axes, then three stages each do one
// multiply-add of the linear address. Reset clears the stage valid bits and
// loads the register defaults. The result side cannot stall, so nothing is held.

module pad_source_index_map_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [psim_pkg::CHAN_W-1:0]         chan_i,
  input  wire logic [psim_pkg::OUTC_W-1:0]         out_z_i,
  input  wire logic [psim_pkg::OUTC_W-1:0]         out_y_i,
  input  wire logic [psim_pkg::OUTC_W-1:0]         out_x_i,
  output logic                                     valid_o,
  output logic [psim_pkg::COORD_BITS-1:0]          src_x_o,
  output logic [psim_pkg::COORD_BITS-1:0]          src_y_o,
  output logic [psim_pkg::COORD_BITS-1:0]          src_z_o,
  output logic [psim_pkg::ADDR_BITS-1:0]           src_address_o,
  output logic                                     use_fill_o,
  output logic [psim_pkg::DATA_BITS-1:0]           fill_out_o,
  output logic                                     out_of_range_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [psim_pkg::CIDX_W-1:0]         cfg_index_i,
  input  wire logic [psim_pkg::CDATA_W-1:0]        cfg_data_i
);

  logic [psim_pkg::MODE_W-1:0]    pad_mode_q;
  logic [psim_pkg::PAD_W-1:0]     pad_left_q, pad_top_q, pad_front_q;
  logic [psim_pkg::DREG_W-1:0]    in_width_q, in_height_q, in_depth_q;
  logic [psim_pkg::DATA_BITS-1:0] fill_value_q;

  logic [psim_pkg::DIM_W-1:0] dim_w, dim_h, dim_d;
  psim_pkg::axis_res_t        res_x, res_y, res_z;
  psim_pkg::side_t            s1_side_d, s1_side_q, out_side;
  logic                       s1_valid_q;
  logic [psim_pkg::CHAN_W-1:0] s1_chan_q;
  logic                       req_accept;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign req_accept  = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_mode_q   <= psim_pkg::PAD_CONST;
      pad_left_q   <= '0;
      pad_top_q    <= '0;
      pad_front_q  <= '0;
      in_width_q   <= psim_pkg::DREG_W'(1);
      in_height_q  <= psim_pkg::DREG_W'(1);
      in_depth_q   <= psim_pkg::DREG_W'(1);
      fill_value_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (psim_pkg::cfg_reg_e'(cfg_index_i))
        psim_pkg::CFG_PAD_MODE:   pad_mode_q   <= cfg_data_i[psim_pkg::MODE_W-1:0];
        psim_pkg::CFG_PAD_LEFT:   pad_left_q   <= cfg_data_i[psim_pkg::PAD_W-1:0];
        psim_pkg::CFG_PAD_TOP:    pad_top_q    <= cfg_data_i[psim_pkg::PAD_W-1:0];
        psim_pkg::CFG_PAD_FRONT:  pad_front_q  <= cfg_data_i[psim_pkg::PAD_W-1:0];
        psim_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg_data_i[psim_pkg::DREG_W-1:0];
        psim_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg_data_i[psim_pkg::DREG_W-1:0];
        psim_pkg::CFG_IN_DEPTH:   in_depth_q   <= cfg_data_i[psim_pkg::DREG_W-1:0];
        psim_pkg::CFG_FILL_VALUE: fill_value_q <= cfg_data_i[psim_pkg::DATA_BITS-1:0];
      endcase
    end
  end

  assign dim_w = psim_pkg::eff_dim(in_width_q);
  assign dim_h = psim_pkg::eff_dim(in_height_q);
  assign dim_d = psim_pkg::eff_dim(in_depth_q);

  psim_axis_map u_map_x (
    .mode_i (pad_mode_q),
    .outc_i (out_x_i),
    .pad_i  (pad_left_q),
    .dim_i  (dim_w),
    .res_o  (res_x)
  );

  psim_axis_map u_map_y (
    .mode_i (pad_mode_q),
    .outc_i (out_y_i),
    .pad_i  (pad_top_q),
    .dim_i  (dim_h),
    .res_o  (res_y)
  );

  psim_axis_map u_map_z (
    .mode_i (pad_mode_q),
    .outc_i (out_z_i),
    .pad_i  (pad_front_q),
    .dim_i  (dim_d),
    .res_o  (res_z)
  );

  always_comb begin
    s1_side_d.fill = res_x.fill || res_y.fill || res_z.fill;
    s1_side_d.bad  = res_x.bad || res_y.bad || res_z.bad;
    s1_side_d.sx   = res_x.coord;
    s1_side_d.sy   = res_y.coord;
    s1_side_d.sz   = res_z.coord;
    // drop all coordinates once any axis misses the source
    if (s1_side_d.fill || s1_side_d.bad) begin
      s1_side_d.sx = '0;
      s1_side_d.sy = '0;
      s1_side_d.sz = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_chan_q <= chan_i;
    s1_side_q <= s1_side_d;
  end

  psim_addr_pipe u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s1_valid_q),
    .chan_i   (s1_chan_q),
    .side_i   (s1_side_q),
    .width_i  (dim_w),
    .height_i (dim_h),
    .depth_i  (dim_d),
    .valid_o  (valid_o),
    .addr_o   (src_address_o),
    .side_o   (out_side)
  );

  assign src_x_o        = out_side.sx;
  assign src_y_o        = out_side.sy;
  assign src_z_o        = out_side.sz;
  assign use_fill_o     = out_side.fill;
  assign out_of_range_o = out_side.bad;
  assign fill_out_o     = out_side.fill ? fill_value_q : '0;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |-> ##4 valid_o)
    else $error("request did not produce a result after four cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(req_accept, 4))
    else $error("result without a matching request");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(use_fill_o && out_of_range_o))
    else $error("fill and out-of-range set together");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (use_fill_o || out_of_range_o) |->
      src_address_o == '0 && src_x_o == '0 && src_y_o == '0 && src_z_o == '0)
    else $error("missed element carries a nonzero address");

  a_bad_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_of_range_o |-> fill_out_o == '0)
    else $error("out-of-range element carries fill data");
`endif

endmodule

`default_nettype wire

>>> src/psim_axis_map.sv
`timescale 1ns / 1ps
`default_nettype none

module psim_axis_map (
  input  wire logic [psim_pkg::MODE_W-1:0] mode_i,
  input  wire logic [psim_pkg::OUTC_W-1:0] outc_i,
  input  wire logic [psim_pkg::PAD_W-1:0]  pad_i,
  input  wire logic [psim_pkg::DIM_W-1:0]  dim_i,
  output psim_pkg::axis_res_t              res_o
);

  localparam int unsigned AW = psim_pkg::AX_W;

  logic signed [AW-1:0] d;
  logic signed [AW-1:0] n;
  logic signed [AW-1:0] nm1;
  logic signed [AW-1:0] s;
  logic signed [AW-1:0] r;
  logic                 below;
  logic                 above;

  always_comb begin
    d     = $signed(AW'(outc_i)) - $signed(AW'(pad_i));
    n     = $signed(AW'(dim_i));
    nm1   = n - $signed(AW'(1));
    below = d < $signed(AW'(0));
    above = d >= n;
    s     = d;
    r     = d;
    res_o = '0;
    unique case (mode_i)
      psim_pkg::PAD_EDGE: begin
        if (below) begin
          s = '0;
        end else if (above) begin
          s = nm1;
        end
        res_o.coord = s[psim_pkg::COORD_BITS-1:0];
      end
      psim_pkg::PAD_REFLECT: begin
        // mirror about the edge element, edge itself not repeated
        if (below) begin
          r = -d;
        end else if (above) begin
          r = (nm1 <<< 1) - d;
        end
        if (r < $signed(AW'(0)) || r >= n) begin
          res_o.bad = 1'b1;
        end else begin
          res_o.coord = r[psim_pkg::COORD_BITS-1:0];
        end
      end
      default: begin
        // constant fill, also for the unused mode code
        if (below || above) begin
          res_o.fill = 1'b1;
        end else begin
          res_o.coord = d[psim_pkg::COORD_BITS-1:0];
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/psim_addr_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module psim_addr_pipe (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  input  wire logic [psim_pkg::CHAN_W-1:0]     chan_i,
  input  wire psim_pkg::side_t                 side_i,
  input  wire logic [psim_pkg::DIM_W-1:0]      width_i,
  input  wire logic [psim_pkg::DIM_W-1:0]      height_i,
  input  wire logic [psim_pkg::DIM_W-1:0]      depth_i,
  output logic                                 valid_o,
  output logic [psim_pkg::ADDR_BITS-1:0]       addr_o,
  output psim_pkg::side_t                      side_o
);

  localparam int unsigned AB = psim_pkg::ADDR_BITS;

  logic            a_valid_q, b_valid_q, c_valid_q;
  logic [AB-1:0]   a_acc_q, b_acc_q, c_acc_q;
  logic [AB-1:0]   a_acc_d, b_acc_d, c_acc_d;
  psim_pkg::side_t a_side_q, b_side_q, c_side_q;

  // one multiply-add per stage, all modulo 2^ADDR_BITS
  always_comb begin
    a_acc_d = AB'(chan_i) * AB'(depth_i) + AB'(side_i.sz);
    b_acc_d = a_acc_q * AB'(height_i) + AB'(a_side_q.sy);
    c_acc_d = b_acc_q * AB'(width_i) + AB'(b_side_q.sx);
    if (b_side_q.fill || b_side_q.bad) begin
      c_acc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_acc_q  <= a_acc_d;
    a_side_q <= side_i;
    b_acc_q  <= b_acc_d;
    b_side_q <= a_side_q;
    c_acc_q  <= c_acc_d;
    c_side_q <= b_side_q;
  end

  assign valid_o = c_valid_q;
  assign addr_o  = c_acc_q;
  assign side_o  = c_side_q;

endmodule

`default_nettype wire

>>> test/pad_source_index_map_checker.sv
`timescale 1ns / 1ps

module pad_source_index_map_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic [psim_pkg::CHAN_W-1:0]       chan_i,
  input  logic [psim_pkg::OUTC_W-1:0]       out_z_i,
  input  logic [psim_pkg::OUTC_W-1:0]       out_y_i,
  input  logic [psim_pkg::OUTC_W-1:0]       out_x_i,
  input  logic                              valid_i,
  input  logic [psim_pkg::COORD_BITS-1:0]   src_x_i,
  input  logic [psim_pkg::COORD_BITS-1:0]   src_y_i,
  input  logic [psim_pkg::COORD_BITS-1:0]   src_z_i,
  input  logic [psim_pkg::ADDR_BITS-1:0]    src_address_i,
  input  logic                              use_fill_i,
  input  logic [psim_pkg::DATA_BITS-1:0]    fill_out_i,
  input  logic                              out_of_range_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [psim_pkg::CIDX_W-1:0]       cfg_index_i,
  input  logic [psim_pkg::CDATA_W-1:0]      cfg_data_i,
  output int unsigned                       mismatches_o,
  output int unsigned                       pending_o,
  output int unsigned                       checked_o
);
  import psim_pkg::*;

  localparam int unsigned SW = 16;

  typedef struct packed {
    logic                  fill;
    logic                  bad;
    logic [COORD_BITS-1:0] coord;
  } axis_map_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] sz;
    logic [ADDR_BITS-1:0]  addr;
    logic                  use_fill;
    logic [DATA_BITS-1:0]  fill;
    logic                  oor;
  } src_map_t;

  logic [MODE_W-1:0]    mode_q;
  logic [PAD_W-1:0]     left_q;
  logic [PAD_W-1:0]     top_q;
  logic [PAD_W-1:0]     front_q;
  logic [DREG_W-1:0]    width_q;
  logic [DREG_W-1:0]    height_q;
  logic [DREG_W-1:0]    depth_q;
  logic [DATA_BITS-1:0] fill_q;

  src_map_t expected_q[$];

  function automatic logic [DIM_W-1:0] usable_dim(input logic [DREG_W-1:0] r);
    if (r == '0) return DIM_W'(1);
    if (int'(r) > (1 << COORD_BITS)) return DIM_W'(1 << COORD_BITS);
    return DIM_W'(r);
  endfunction

  function automatic axis_map_t fold_axis(input logic [OUTC_W-1:0] oc,
                                          input logic [PAD_W-1:0] pad,
                                          input logic [DIM_W-1:0] n);
    axis_map_t res;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] last;
    res  = '0;
    d    = $signed(SW'(oc)) - $signed(SW'(pad));
    last = $signed(SW'(n)) - 1;
    s    = d;
    if (mode_q == PAD_EDGE) begin
      if (s < 0) s = 0;
      if (s > last) s = last;
      res.coord = s[COORD_BITS-1:0];
    end else if (mode_q == PAD_REFLECT) begin
      // mirror about the edge element without repeating it
      if (d < 0) s = -d;
      else if (d > last) s = 2 * last - d;
      if (s < 0 || s > last) res.bad = 1'b1;
      else res.coord = s[COORD_BITS-1:0];
    end else begin
      // constant fill, also taken for the unused mode code
      if (d < 0 || d > last) res.fill = 1'b1;
      else res.coord = s[COORD_BITS-1:0];
    end
    return res;
  endfunction

  function automatic src_map_t map_element(input logic [CHAN_W-1:0] chan,
                                           input logic [OUTC_W-1:0] oz,
                                           input logic [OUTC_W-1:0] oy,
                                           input logic [OUTC_W-1:0] ox);
    src_map_t res;
    axis_map_t ax;
    axis_map_t ay;
    axis_map_t az;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] dp;
    logic [ADDR_BITS-1:0] a;
    w  = usable_dim(width_q);
    h  = usable_dim(height_q);
    dp = usable_dim(depth_q);
    ax = fold_axis(ox, left_q, w);
    ay = fold_axis(oy, top_q, h);
    az = fold_axis(oz, front_q, dp);
    res = '0;
    res.use_fill = ax.fill | ay.fill | az.fill;
    res.oor      = ax.bad | ay.bad | az.bad;
    if (!res.use_fill && !res.oor) begin
      res.sx = ax.coord;
      res.sy = ay.coord;
      res.sz = az.coord;
      // wrap at the address width on every multiply-add
      a = ADDR_BITS'(chan) * ADDR_BITS'(dp) + ADDR_BITS'(az.coord);
      a = a * ADDR_BITS'(h) + ADDR_BITS'(ay.coord);
      a = a * ADDR_BITS'(w) + ADDR_BITS'(ax.coord);
      res.addr = a;
    end
    if (res.use_fill) res.fill = fill_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches_o++;
    if (mismatches_o <= 100) begin
      $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
    end
  endtask

  initial begin
    mismatches_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    src_map_t want;
    if (!rst_ni) begin
      mode_q   = PAD_CONST;
      left_q   = '0;
      top_q    = '0;
      front_q  = '0;
      width_q  = DREG_W'(1);
      height_q = DREG_W'(1);
      depth_q  = DREG_W'(1);
      fill_q   = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PAD_MODE:   mode_q   = cfg_data_i[MODE_W-1:0];
          CFG_PAD_LEFT:   left_q   = cfg_data_i[PAD_W-1:0];
          CFG_PAD_TOP:    top_q    = cfg_data_i[PAD_W-1:0];
          CFG_PAD_FRONT:  front_q  = cfg_data_i[PAD_W-1:0];
          CFG_IN_WIDTH:   width_q  = cfg_data_i[DREG_W-1:0];
          CFG_IN_HEIGHT:  height_q = cfg_data_i[DREG_W-1:0];
          CFG_IN_DEPTH:   depth_q  = cfg_data_i[DREG_W-1:0];
          CFG_FILL_VALUE: fill_q   = cfg_data_i[DATA_BITS-1:0];
          default: ;
        endcase
      end
      if (valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with no pending request", '0, '0);
        end else begin
          want = expected_q.pop_front();
          if (src_x_i !== want.sx) report_mismatch("src_x", want.sx, src_x_i);
          if (src_y_i !== want.sy) report_mismatch("src_y", want.sy, src_y_i);
          if (src_z_i !== want.sz) report_mismatch("src_z", want.sz, src_z_i);
          if (src_address_i !== want.addr)
            report_mismatch("src_address", want.addr, src_address_i);
          if (use_fill_i !== want.use_fill)
            report_mismatch("use_fill", want.use_fill, use_fill_i);
          if (fill_out_i !== want.fill) report_mismatch("fill_out", want.fill, fill_out_i);
          if (out_of_range_i !== want.oor)
            report_mismatch("out_of_range", want.oor, out_of_range_i);
          checked_o++;
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(map_element(chan_i, out_z_i, out_y_i, out_x_i));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

>>> test/tb_pad_source_index_map_core.sv
`timescale 1ns / 1ps

module tb_pad_source_index_map_core;
  import psim_pkg::*;

  localparam int unsigned LATENCY         = 4;
  localparam int unsigned CYCLE_LIMIT     = 100000;
  localparam int unsigned RANDOM_PHASES   = 14;
  localparam int unsigned ITEMS_PER_PHASE = 100;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic [CHAN_W-1:0]     chan      = '0;
  logic [OUTC_W-1:0]     out_z     = '0;
  logic [OUTC_W-1:0]     out_y     = '0;
  logic [OUTC_W-1:0]     out_x     = '0;
  logic                  cfg_valid = 1'b0;
  logic [CIDX_W-1:0]     cfg_index = '0;
  logic [CDATA_W-1:0]    cfg_data  = '0;

  logic                  busy;
  logic                  valid;
  logic [COORD_BITS-1:0] src_x;
  logic [COORD_BITS-1:0] src_y;
  logic [COORD_BITS-1:0] src_z;
  logic [ADDR_BITS-1:0]  src_address;
  logic                  use_fill;
  logic [DATA_BITS-1:0]  fill_out;
  logic                  out_of_range;
  logic                  cfg_ready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles   = 0;
  int unsigned sent     = 0;
  int unsigned settings = 0;
  bit          gaps_on  = 1'b1;

  // current geometry, used only to aim coordinates near the source edges
  int unsigned cur_left;
  int unsigned cur_top;
  int unsigned cur_front;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned cur_d;

  pad_source_index_map_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .chan_i         (chan),
    .out_z_i        (out_z),
    .out_y_i        (out_y),
    .out_x_i        (out_x),
    .valid_o        (valid),
    .src_x_o        (src_x),
    .src_y_o        (src_y),
    .src_z_o        (src_z),
    .src_address_o  (src_address),
    .use_fill_o     (use_fill),
    .fill_out_o     (fill_out),
    .out_of_range_o (out_of_range),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  pad_source_index_map_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .chan_i         (chan),
    .out_z_i        (out_z),
    .out_y_i        (out_y),
    .out_x_i        (out_x),
    .valid_i        (valid),
    .src_x_i        (src_x),
    .src_y_i        (src_y),
    .src_z_i        (src_z),
    .src_address_i  (src_address),
    .use_fill_i     (use_fill),
    .fill_out_i     (fill_out),
    .out_of_range_i (out_of_range),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("pad_source_index_map_core test failed");
      $finish;
    end
  end

  task automatic idle(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if (gaps_on && $urandom_range(0, 99) < 18) idle($urandom_range(1, 4));
  endtask

  task automatic issue(input logic [CHAN_W-1:0] c, input logic [OUTC_W-1:0] z,
                       input logic [OUTC_W-1:0] y, input logic [OUTC_W-1:0] x);
    chan  <= c;
    out_z <= z;
    out_y <= y;
    out_x <= x;
    start <= 1'b1;
    // busy only changes at the edge, so its value at the falling edge decides
    do @(negedge clk); while (busy);
    @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    if ($urandom_range(0, 99) < 18) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // set bits above the register width to garbage; the block must drop them
  function automatic logic [CDATA_W-1:0] with_junk(input logic [CDATA_W-1:0] value,
                                                   input int unsigned width);
    logic [CDATA_W-1:0] keep;
    keep = (width >= CDATA_W) ? '1 : ((CDATA_W'(1) << width) - 1);
    return (CDATA_W'($urandom) & ~keep) | (value & keep);
  endfunction

  task automatic set_geometry(input logic [MODE_W-1:0] mode, input int unsigned l,
                              input int unsigned t, input int unsigned f,
                              input int unsigned w, input int unsigned h,
                              input int unsigned d, input logic [DATA_BITS-1:0] fv);
    drain();
    write_reg(CFG_PAD_MODE,   with_junk(CDATA_W'(mode), MODE_W));
    write_reg(CFG_PAD_LEFT,   with_junk(CDATA_W'(l), PAD_W));
    write_reg(CFG_PAD_TOP,    with_junk(CDATA_W'(t), PAD_W));
    write_reg(CFG_PAD_FRONT,  with_junk(CDATA_W'(f), PAD_W));
    write_reg(CFG_IN_WIDTH,   with_junk(CDATA_W'(w), DREG_W));
    write_reg(CFG_IN_HEIGHT,  with_junk(CDATA_W'(h), DREG_W));
    write_reg(CFG_IN_DEPTH,   with_junk(CDATA_W'(d), DREG_W));
    write_reg(CFG_FILL_VALUE, CDATA_W'(fv));
    cfg_valid <= 1'b0;
    cur_left  = l;
    cur_top   = t;
    cur_front = f;
    cur_w     = w;
    cur_h     = h;
    cur_d     = d;
    settings++;
  endtask

  function automatic logic [OUTC_W-1:0] pick_coord(input int unsigned pad,
                                                   input int unsigned dimreg);
    int unsigned n;
    int unsigned hi;
    n = (dimreg == 0) ? 1 : ((dimreg > 4096) ? 4096 : dimreg);
    if ($urandom_range(0, 99) < 80) begin
      hi = pad + 2 * n + 1;
      if (hi > 8191) hi = 8191;
      return OUTC_W'($urandom_range(0, hi));
    end
    return OUTC_W'($urandom_range(0, 8191));
  endfunction

  function automatic int unsigned rand_pad();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 4);
    if (r < 80) return $urandom_range(0, 40);
    return $urandom_range(0, 1023);
  endfunction

  function automatic int unsigned rand_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return $urandom_range(4097, 8191);
    if (r < 30) return 4096;
    return $urandom_range(1, 12);
  endfunction

  initial begin : stimulus
    logic [MODE_W-1:0] mode;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults straight out of reset
    issue(0, 0, 0, 0);
    issue(1023, 8191, 8191, 8191);

    // constant fill: inside corners, then each axis outside
    set_geometry(PAD_CONST, 2, 1, 1, 4, 3, 2, 32'hDEAD_BEEF);
    issue(5, 1, 1, 2);
    issue(3, 2, 3, 5);
    issue(0, 0, 1, 2);
    issue(0, 1, 4, 2);
    issue(0, 1, 1, 6);

    // edge clamp below, above and inside
    set_geometry(PAD_EDGE, 3, 3, 3, 5, 5, 5, 32'h1234_5678);
    issue(7, 0, 0, 0);
    issue(7, 8191, 8191, 8191);
    issue(1, 4, 5, 6);

    // reflect on a 2D image: both sides, past the far side, depth of one
    set_geometry(PAD_REFLECT, 3, 2, 0, 4, 3, 1, 32'h0F0F_F0F0);
    issue(2, 0, 2, 0);
    issue(2, 0, 2, 7);
    issue(2, 0, 2, 10);
    issue(2, 1, 2, 3);
    issue(2, 0, 0, 3);

    // unused mode code with zero dimensions
    set_geometry(2'd3, 1, 1, 1, 0, 0, 0, 32'hFFFF_FFFF);
    issue(9, 1, 1, 1);
    issue(9, 0, 1, 1);

    // largest pads, oversized dimensions, address wrap
    set_geometry(PAD_EDGE, 1023, 1023, 1023, 8191, 8191, 4096, 32'h0);
    issue(1023, 8191, 8191, 8191);
    issue(1023, 0, 0, 0);
    issue(512, 1123, 3023, 5118);

    set_geometry(PAD_REFLECT, 1023, 0, 1023, 4096, 1, 4096, 32'hA5A5_5A5A);
    issue(1023, 0, 0, 0);
    issue(1023, 8191, 0, 8191);
    issue(1023, 0, 1, 0);

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      mode = ($urandom_range(0, 99) < 10) ? 2'd3 : MODE_W'($urandom_range(0, 2));
      set_geometry(mode, rand_pad(), rand_pad(), rand_pad(), rand_dim(), rand_dim(),
                   rand_dim(), DATA_BITS'($urandom));
      // hold the request line busy back to back for a few phases
      gaps_on = !(p >= 6 && p <= 8);
      for (int unsigned i = 0; i < ITEMS_PER_PHASE; i++) begin
        maybe_idle();
        issue(CHAN_W'($urandom_range(0, 1023)), pick_coord(cur_front, cur_d),
              pick_coord(cur_top, cur_h), pick_coord(cur_left, cur_w));
      end
    end

    drain();
    idle(2 * LATENCY);
    @(negedge clk);
    if (pending != 0) $display("%0d results never arrived", pending);
    $display("%0d requests under %0d register settings, %0d results checked",
             sent, settings, checked);
    $display("modes constant, edge, reflect and unused; zero, small, full, oversized sizes");
    if (mismatches == 0 && pending == 0) begin
      $display("pad_source_index_map_core test passed");
    end else begin
      $display("pad_source_index_map_core test failed");
    end
    $finish;
  end

endmodule
